// ----- hw/rtl/vmrf_pkg.sv -----
package vmrf_pkg;

   // frame geometry
   localparam int FRAME_BYTES = 36;
   localparam int IDX_W       = $clog2(FRAME_BYTES);

   typedef logic [IDX_W-1:0] idx_type;

   // byte positions inside the frame
   localparam idx_type POS_START    = idx_type'(0);
   localparam idx_type POS_LEN_LO   = idx_type'(1);
   localparam idx_type POS_LEN_HI   = idx_type'(2);
   localparam idx_type POS_CTRL_LO  = idx_type'(3);
   localparam idx_type POS_CTRL_HI  = idx_type'(4);
   localparam idx_type POS_SEQ      = idx_type'(5);
   localparam idx_type POS_SEQ_PAD  = idx_type'(6);
   localparam idx_type POS_SER_0    = idx_type'(7);
   localparam idx_type POS_SER_1    = idx_type'(8);
   localparam idx_type POS_SER_2    = idx_type'(9);
   localparam idx_type POS_SER_3    = idx_type'(10);
   localparam idx_type POS_PTYPE    = idx_type'(11);
   localparam idx_type POS_SLAVE    = idx_type'(26);
   localparam idx_type POS_FUNC     = idx_type'(27);
   localparam idx_type POS_ADDR_HI  = idx_type'(28);
   localparam idx_type POS_ADDR_LO  = idx_type'(29);
   localparam idx_type POS_CNT_HI   = idx_type'(30);
   localparam idx_type POS_CNT_LO   = idx_type'(31);
   localparam idx_type POS_CRC_LO   = idx_type'(32);
   localparam idx_type POS_CRC_HI   = idx_type'(33);
   localparam idx_type POS_SUM      = idx_type'(34);
   localparam idx_type POS_END      = idx_type'(35);

   // fixed byte values
   localparam logic [7:0] START_BYTE  = 8'hA5;
   localparam logic [7:0] LEN_LO_BYTE = 8'h17;
   localparam logic [7:0] CTRL_LO     = 8'h10;
   localparam logic [7:0] CTRL_HI     = 8'h45;
   localparam logic [7:0] PTYPE_BYTE  = 8'h02;
   localparam logic [7:0] FUNC_READ   = 8'h03;
   localparam logic [7:0] END_BYTE    = 8'h15;
   localparam logic [7:0] ZERO_BYTE   = 8'h00;
   localparam logic [7:0] SEQ_RESET   = 8'h45;

   // crc-16 modbus
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   // register indexes
   localparam logic [7:0] CSR_SLAVE_ID      = 8'd0;
   localparam logic [7:0] CSR_LOGGER_SERIAL = 8'd1;
   localparam logic [7:0] SLAVE_ID_RESET    = 8'd1;

   typedef struct packed {
      logic [15:0] start_address;
      logic [15:0] register_count;
   } req_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic       last;
   } gen_byte_type;

   // one byte of the reflected crc update
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int b = 0; b < 8; b++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ----- hw/rtl/vmrf_req_reg.sv -----
module vmrf_req_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [15:0]      req_start_address,
   input  logic [15:0]      req_register_count,
   input  logic             take,
   output logic             pend_valid,
   output vmrf_pkg::req_type pend
);

   logic              pend_valid_ff, pend_valid_in;
   vmrf_pkg::req_type pend_ff, pend_in;
   logic              accept;

   // hold one request while the current frame streams out
   assign req_ready = !pend_valid_ff;
   assign accept    = req_valid && req_ready;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      if (take) begin
         pend_valid_in = 1'b0;
      end
      if (accept) begin
         pend_valid_in          = 1'b1;
         pend_in.start_address  = req_start_address;
         pend_in.register_count = req_register_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
      end
      pend_ff <= pend_in;
   end

   assign pend_valid = pend_valid_ff;
   assign pend       = pend_ff;

endmodule

// ----- hw/rtl/vmrf_frame_gen.sv -----
module vmrf_frame_gen (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pend_valid,
   input  vmrf_pkg::req_type      pend,
   output logic                   take,
   input  logic [7:0]             slave_id,
   input  logic [31:0]            logger_serial,
   input  logic                   out_ready,
   output vmrf_pkg::gen_byte_type gen
);

   logic              active_ff, active_in;
   vmrf_pkg::idx_type idx_ff, idx_in;
   vmrf_pkg::req_type cur_ff, cur_in;
   logic [15:0]       crc_ff, crc_in;
   logic [7:0]        sum_ff, sum_in;
   logic [7:0]        seq_ff, seq_in;
   logic [7:0]        byte_val;
   logic              step;
   logic              at_end;

   assign step   = active_ff && out_ready;
   assign at_end = (idx_ff == vmrf_pkg::POS_END);
   assign take   = pend_valid && (!active_ff || (step && at_end));

   // byte select by position
   always_comb begin
      case (idx_ff)
         vmrf_pkg::POS_START:   byte_val = vmrf_pkg::START_BYTE;
         vmrf_pkg::POS_LEN_LO:  byte_val = vmrf_pkg::LEN_LO_BYTE;
         vmrf_pkg::POS_LEN_HI:  byte_val = vmrf_pkg::ZERO_BYTE;
         vmrf_pkg::POS_CTRL_LO: byte_val = vmrf_pkg::CTRL_LO;
         vmrf_pkg::POS_CTRL_HI: byte_val = vmrf_pkg::CTRL_HI;
         vmrf_pkg::POS_SEQ:     byte_val = seq_ff;
         vmrf_pkg::POS_SEQ_PAD: byte_val = vmrf_pkg::ZERO_BYTE;
         vmrf_pkg::POS_SER_0:   byte_val = logger_serial[7:0];
         vmrf_pkg::POS_SER_1:   byte_val = logger_serial[15:8];
         vmrf_pkg::POS_SER_2:   byte_val = logger_serial[23:16];
         vmrf_pkg::POS_SER_3:   byte_val = logger_serial[31:24];
         vmrf_pkg::POS_PTYPE:   byte_val = vmrf_pkg::PTYPE_BYTE;
         vmrf_pkg::POS_SLAVE:   byte_val = slave_id;
         vmrf_pkg::POS_FUNC:    byte_val = vmrf_pkg::FUNC_READ;
         vmrf_pkg::POS_ADDR_HI: byte_val = cur_ff.start_address[15:8];
         vmrf_pkg::POS_ADDR_LO: byte_val = cur_ff.start_address[7:0];
         vmrf_pkg::POS_CNT_HI:  byte_val = cur_ff.register_count[15:8];
         vmrf_pkg::POS_CNT_LO:  byte_val = cur_ff.register_count[7:0];
         vmrf_pkg::POS_CRC_LO:  byte_val = crc_ff[7:0];
         vmrf_pkg::POS_CRC_HI:  byte_val = crc_ff[15:8];
         vmrf_pkg::POS_SUM:     byte_val = sum_ff;
         vmrf_pkg::POS_END:     byte_val = vmrf_pkg::END_BYTE;
         default:               byte_val = vmrf_pkg::ZERO_BYTE;
      endcase
   end

   // position counter, running crc and checksum
   always_comb begin
      active_in = active_ff;
      idx_in    = idx_ff;
      cur_in    = cur_ff;
      crc_in    = crc_ff;
      sum_in    = sum_ff;
      seq_in    = seq_ff;
      if (step) begin
         idx_in = idx_ff + vmrf_pkg::idx_type'(1);
         if (idx_ff inside {[vmrf_pkg::POS_SLAVE : vmrf_pkg::POS_CNT_LO]}) begin
            crc_in = vmrf_pkg::crc_byte(crc_ff, byte_val);
         end
         if (idx_ff inside {[vmrf_pkg::POS_LEN_LO : vmrf_pkg::POS_CRC_HI]}) begin
            sum_in = sum_ff + byte_val;
         end
         if (at_end) begin
            active_in = 1'b0;
            seq_in    = seq_ff + 8'd1;
         end
      end
      if (take) begin
         active_in = 1'b1;
         idx_in    = vmrf_pkg::POS_START;
         cur_in    = pend;
         crc_in    = vmrf_pkg::CRC_INIT;
         sum_in    = vmrf_pkg::ZERO_BYTE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         idx_ff    <= vmrf_pkg::POS_START;
         seq_ff    <= vmrf_pkg::SEQ_RESET;
      end else begin
         active_ff <= active_in;
         idx_ff    <= idx_in;
         seq_ff    <= seq_in;
      end
      cur_ff <= cur_in;
      crc_ff <= crc_in;
      sum_ff <= sum_in;
   end

   assign gen.valid = active_ff;
   assign gen.data  = byte_val;
   assign gen.last  = at_end;

endmodule

// ----- hw/rtl/vmrf_rsp_reg.sv -----
module vmrf_rsp_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  vmrf_pkg::gen_byte_type gen,
   output logic                   out_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_frame_byte,
   output logic                   rsp_last_byte
);

   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       last_ff, last_in;

   // result register loads whenever it is empty or being drained
   assign out_ready = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      if (out_ready) begin
         valid_in = gen.valid;
         data_in  = gen.data;
         last_in  = gen.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_frame_byte = data_ff;
   assign rsp_last_byte  = last_ff;

endmodule

// ----- hw/rtl/v5_modbus_request_framer_top.sv -----
// Read-request framer: each accepted transaction (start address, register count) becomes a
// 36-byte logger frame wrapping a Modbus RTU read-holding-registers request, streamed one
// byte per cycle while rsp_ready is high on the rsp channel, with rsp_last_byte marking the
// closing 0x15. While one frame streams out, one further request is held in the input
// register, so consecutive frames leave with no gap. The first byte of a frame passes through
// the holding register, the generator's position register and the result register before it
// reaches rsp_valid. CRC and checksum are built up byte by byte as the frame goes out. The
// sequence number starts at 0x45 after reset and advances after every frame. slave_id and
// logger_serial are read live and are to be written only while no frame is in flight.
module v5_modbus_request_framer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_start_address,
   input  logic [15:0] req_register_count,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_frame_byte,
   output logic        rsp_last_byte,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_index,
   input  logic [31:0] csr_write_data
);

   logic [7:0]             slave_id_r_ff, slave_id_r_in;
   logic [31:0]            serial_ff, serial_in;
   logic                   pend_valid;
   vmrf_pkg::req_type      pend;
   logic                   take;
   logic                   out_ready;
   vmrf_pkg::gen_byte_type gen;

   // configuration registers
   always_comb begin
      slave_id_r_in = slave_id_r_ff;
      serial_in     = serial_ff;
      if (csr_write_enable) begin
         case (csr_index)
            vmrf_pkg::CSR_SLAVE_ID:      slave_id_r_in = csr_write_data[7:0];
            vmrf_pkg::CSR_LOGGER_SERIAL: serial_in     = csr_write_data;
            default:                     slave_id_r_in = slave_id_r_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_id_r_ff <= vmrf_pkg::SLAVE_ID_RESET;
         serial_ff     <= '0;
      end else begin
         slave_id_r_ff <= slave_id_r_in;
         serial_ff     <= serial_in;
      end
   end

   vmrf_req_reg u_req_reg (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_start_address  (req_start_address),
      .req_register_count (req_register_count),
      .take               (take),
      .pend_valid         (pend_valid),
      .pend               (pend)
   );

   vmrf_frame_gen u_frame_gen (
      .clock         (clock),
      .reset         (reset),
      .pend_valid    (pend_valid),
      .pend          (pend),
      .take          (take),
      .slave_id      (slave_id_r_ff),
      .logger_serial (serial_ff),
      .out_ready     (out_ready),
      .gen           (gen)
   );

   vmrf_rsp_reg u_rsp_reg (
      .clock          (clock),
      .reset          (reset),
      .gen            (gen),
      .out_ready      (out_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_last_byte  (rsp_last_byte)
   );

   // the closing byte is always the end marker
   a_last_is_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_byte) |-> (rsp_frame_byte == vmrf_pkg::END_BYTE))
      else $error("last byte is not the end marker");

   // an accepted request fills the holding register
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("holding register not filled after accept");

   // the generator's last byte lands in the result register
   a_last_forwarded: assert property (@(posedge clock) disable iff (reset)
      (gen.valid && gen.last && out_ready) |=> (rsp_valid && rsp_last_byte))
      else $error("last byte lost between generator and result register");

   // a frame only starts from a pending request
   a_take_needs_pending: assert property (@(posedge clock) disable iff (reset)
      take |-> pend_valid)
      else $error("frame started without a pending request");

endmodule

// ----- tb/v5_modbus_request_framer_top_tb.sv -----
`timescale 1ns / 1ps

module v5_modbus_request_framer_top_tb;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_ITEMS  = 246;
   localparam int RANDOM_PHASES = 6;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 40;
   localparam int REPORT_MAX    = 10;

   // register indexes the block has no register for
   localparam logic [7:0] CSR_UNUSED_IDX = 8'd2;
   localparam logic [7:0] CSR_TOP_IDX    = 8'hFF;

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   // one directed step: a request, or a register write (index in a[7:0])
   typedef struct packed {
      row_kind_type      kind;
      logic [15:0]       a;
      logic [15:0]       b;
      logic [31:0]       data;
      logic              spot;
      vmrf_pkg::idx_type pos;
      logic [7:0]        val;
   } plan_row_type;

   typedef struct packed {
      logic [7:0]        octet;
      logic              last;
      vmrf_pkg::idx_type pos;
   } frame_entry_type;

   // directed steps; a spot value replaces the predicted byte at that position
   localparam plan_row_type DIRECTED_PLAN [27] = '{
      '{ROW_REQ, 16'h0000, 16'h0001, 32'h0, 1'b1, vmrf_pkg::POS_SEQ, 8'h45},
      '{ROW_REQ, 16'h0000, 16'h0001, 32'h0, 1'b1, vmrf_pkg::POS_SLAVE, 8'h01},
      '{ROW_REQ, 16'h0000, 16'h0000, 32'h0, 1'b1, vmrf_pkg::POS_SER_0, 8'h00},
      '{ROW_REQ, 16'hFFFF, 16'hFFFF, 32'h0, 1'b1, vmrf_pkg::POS_ADDR_HI, 8'hFF},
      '{ROW_REQ, 16'hFFFF, 16'h0000, 32'h0, 1'b1, vmrf_pkg::POS_CNT_HI, 8'h00},
      '{ROW_REQ, 16'h0000, 16'hFFFF, 32'h0, 1'b1, vmrf_pkg::POS_END, 8'h15},
      '{ROW_REQ, 16'h8000, 16'h0001, 32'h0, 1'b1, vmrf_pkg::POS_ADDR_HI, 8'h80},
      '{ROW_REQ, 16'h00FF, 16'hFF00, 32'h0, 1'b1, vmrf_pkg::POS_ADDR_LO, 8'hFF},
      '{ROW_CSR, {8'h00, vmrf_pkg::CSR_SLAVE_ID}, 16'h0, 32'hFFFF_FFFF,
        1'b0, vmrf_pkg::POS_START, 8'h00},
      '{ROW_CSR, {8'h00, vmrf_pkg::CSR_LOGGER_SERIAL}, 16'h0, 32'hFFFF_FFFF,
        1'b0, vmrf_pkg::POS_START, 8'h00},
      '{ROW_REQ, 16'h1234, 16'h007D, 32'h0, 1'b1, vmrf_pkg::POS_SLAVE, 8'hFF},
      '{ROW_REQ, 16'h0000, 16'h0000, 32'h0, 1'b1, vmrf_pkg::POS_SER_3, 8'hFF},
      '{ROW_REQ, 16'hFFFF, 16'hFFFF, 32'h0, 1'b0, vmrf_pkg::POS_START, 8'h00},
      '{ROW_REQ, 16'h0001, 16'h8000, 32'h0, 1'b1, vmrf_pkg::POS_CNT_HI, 8'h80},
      '{ROW_CSR, {8'h00, vmrf_pkg::CSR_SLAVE_ID}, 16'h0, 32'h0000_0000,
        1'b0, vmrf_pkg::POS_START, 8'h00},
      '{ROW_CSR, {8'h00, vmrf_pkg::CSR_LOGGER_SERIAL}, 16'h0, 32'h0000_0000,
        1'b0, vmrf_pkg::POS_START, 8'h00},
      '{ROW_CSR, {8'h00, CSR_UNUSED_IDX}, 16'h0, 32'hFFFF_FFFF,
        1'b0, vmrf_pkg::POS_START, 8'h00},
      '{ROW_CSR, {8'h00, CSR_TOP_IDX}, 16'h0, 32'h1234_5678,
        1'b0, vmrf_pkg::POS_START, 8'h00},
      '{ROW_REQ, 16'h0000, 16'h0000, 32'h0, 1'b1, vmrf_pkg::POS_SLAVE, 8'h00},
      '{ROW_REQ, 16'hFFFF, 16'hFFFF, 32'h0, 1'b1, vmrf_pkg::POS_SER_0, 8'h00},
      '{ROW_CSR, {8'h00, vmrf_pkg::CSR_LOGGER_SERIAL}, 16'h0, 32'h89AB_CDEF,
        1'b0, vmrf_pkg::POS_START, 8'h00},
      '{ROW_CSR, {8'h00, vmrf_pkg::CSR_SLAVE_ID}, 16'h0, 32'hFFFF_FF5A,
        1'b0, vmrf_pkg::POS_START, 8'h00},
      '{ROW_REQ, 16'h0100, 16'h0010, 32'h0, 1'b1, vmrf_pkg::POS_SER_0, 8'hEF},
      '{ROW_REQ, 16'h0100, 16'h0010, 32'h0, 1'b1, vmrf_pkg::POS_SER_3, 8'h89},
      '{ROW_REQ, 16'h0000, 16'h0001, 32'h0, 1'b1, vmrf_pkg::POS_SLAVE, 8'h5A},
      '{ROW_REQ, 16'h0000, 16'h0001, 32'h0, 1'b1, vmrf_pkg::POS_FUNC, 8'h03},
      '{ROW_REQ, 16'hAAAA, 16'h5555, 32'h0, 1'b1, vmrf_pkg::POS_PTYPE, 8'h02}
   };

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [15:0] req_start_address;
   logic [15:0] req_register_count;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_frame_byte;
   logic        rsp_last_byte;
   logic        csr_write_enable;
   logic [7:0]  csr_index;
   logic [31:0] csr_write_data;

   // predictor state
   logic [7:0]      model_slave;
   logic [31:0]     model_serial;
   logic [7:0]      model_seq;
   frame_entry_type pending_bytes [$];

   int              mismatch_count = 0;
   int              cycle_count = 0;
   int              burst_left = 0;
   frame_entry_type want;

   // receiver stall state
   int stall_pct = 0;
   int pattern_left = 0;
   int hold_left = 0;
   bit hold_go = 1'b0;
   bit hold_taken = 1'b0;

   v5_modbus_request_framer_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_start_address  (req_start_address),
      .req_register_count (req_register_count),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_frame_byte     (rsp_frame_byte),
      .rsp_last_byte      (rsp_last_byte),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always #5 clock = ~clock;

   // crc-16 over the six request bytes, first byte in the top bits, lsb first per byte
   function automatic logic [15:0] rtu_crc(input logic [47:0] msg);
      logic [15:0] acc;
      logic        fb;
      acc = vmrf_pkg::CRC_INIT;
      for (int k = 0; k < 6; k++) begin
         for (int b = 0; b < 8; b++) begin
            fb  = acc[0] ^ msg[40 - 8*k + b];
            acc = acc >> 1;
            if (fb) begin
               acc = acc ^ vmrf_pkg::CRC_POLY;
            end
         end
      end
      return acc;
   endfunction

   // expected frame for one accepted request; advances the sequence number
   function automatic void build_frame(input logic [15:0] addr, input logic [15:0] cnt,
                                       input logic spot, input vmrf_pkg::idx_type pos,
                                       input logic [7:0] val);
      logic [7:0]      f [vmrf_pkg::FRAME_BYTES];
      logic [15:0]     crc;
      logic [7:0]      sum;
      frame_entry_type e;
      crc = rtu_crc({model_slave, vmrf_pkg::FUNC_READ, addr, cnt});
      f[vmrf_pkg::POS_START]   = vmrf_pkg::START_BYTE;
      f[vmrf_pkg::POS_LEN_LO]  = vmrf_pkg::LEN_LO_BYTE;
      f[vmrf_pkg::POS_LEN_HI]  = vmrf_pkg::ZERO_BYTE;
      f[vmrf_pkg::POS_CTRL_LO] = vmrf_pkg::CTRL_LO;
      f[vmrf_pkg::POS_CTRL_HI] = vmrf_pkg::CTRL_HI;
      f[vmrf_pkg::POS_SEQ]     = model_seq;
      f[vmrf_pkg::POS_SEQ_PAD] = vmrf_pkg::ZERO_BYTE;
      f[vmrf_pkg::POS_SER_0]   = model_serial[7:0];
      f[vmrf_pkg::POS_SER_1]   = model_serial[15:8];
      f[vmrf_pkg::POS_SER_2]   = model_serial[23:16];
      f[vmrf_pkg::POS_SER_3]   = model_serial[31:24];
      f[vmrf_pkg::POS_PTYPE]   = vmrf_pkg::PTYPE_BYTE;
      for (int i = vmrf_pkg::POS_PTYPE + 1; i < vmrf_pkg::POS_SLAVE; i++) begin
         f[i] = vmrf_pkg::ZERO_BYTE;
      end
      f[vmrf_pkg::POS_SLAVE]   = model_slave;
      f[vmrf_pkg::POS_FUNC]    = vmrf_pkg::FUNC_READ;
      f[vmrf_pkg::POS_ADDR_HI] = addr[15:8];
      f[vmrf_pkg::POS_ADDR_LO] = addr[7:0];
      f[vmrf_pkg::POS_CNT_HI]  = cnt[15:8];
      f[vmrf_pkg::POS_CNT_LO]  = cnt[7:0];
      f[vmrf_pkg::POS_CRC_LO]  = crc[7:0];
      f[vmrf_pkg::POS_CRC_HI]  = crc[15:8];
      sum = 8'h00;
      for (int i = vmrf_pkg::POS_LEN_LO; i <= vmrf_pkg::POS_CRC_HI; i++) begin
         sum = sum + f[i];
      end
      f[vmrf_pkg::POS_SUM] = sum;
      f[vmrf_pkg::POS_END] = vmrf_pkg::END_BYTE;
      model_seq = model_seq + 8'h01;
      for (int i = 0; i < vmrf_pkg::FRAME_BYTES; i++) begin
         e.pos   = vmrf_pkg::idx_type'(i);
         e.octet = (spot && pos == vmrf_pkg::idx_type'(i)) ? val : f[i];
         e.last  = (i == vmrf_pkg::FRAME_BYTES - 1);
         pending_bytes.push_back(e);
      end
   endfunction

   function automatic void model_csr(input logic [7:0] idx, input logic [31:0] data);
      if (idx == vmrf_pkg::CSR_SLAVE_ID) begin
         model_slave = data[7:0];
      end else if (idx == vmrf_pkg::CSR_LOGGER_SERIAL) begin
         model_serial = data;
      end
   endfunction

   // mostly uniform values, some corners and walking bits
   function automatic logic [15:0] pick_field();
      logic [15:0] one_hot;
      one_hot = 16'h0001 << $urandom_range(0, 15);
      case ($urandom_range(0, 9))
         0: begin
            return 16'h0000;
         end
         1: begin
            return 16'hFFFF;
         end
         2: begin
            return one_hot;
         end
         3: begin
            return ~one_hot;
         end
         default: begin
            return 16'($urandom);
         end
      endcase
   endfunction

   // offer one request in bursts with random gaps, predict on acceptance
   task automatic send_request(input logic [15:0] addr, input logic [15:0] cnt,
                               input logic spot, input vmrf_pkg::idx_type pos,
                               input logic [7:0] val);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 8);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid          <= 1'b1;
      req_start_address  <= addr;
      req_register_count <= cnt;
      do @(posedge clock); while (!req_ready);
      build_frame(addr, cnt, spot, pos, val);
   endtask

   // drop valid and let every outstanding frame drain
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [7:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      model_csr(idx, data);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // receiver: random stall pattern, one long hold-off on request
   always @(negedge clock) begin
      if (hold_go && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left  = HOLD_CYCLES;
      end
      if (pattern_left == 0) begin
         pattern_left = $urandom_range(16, 160);
         case ($urandom_range(0, 4))
            0, 1: begin
               stall_pct = 0;
            end
            2: begin
               stall_pct = 20;
            end
            3: begin
               stall_pct = 50;
            end
            default: begin
               stall_pct = 80;
            end
         endcase
      end
      pattern_left--;
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // compare each accepted frame byte against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_bytes.size() == 0) begin
            if (mismatch_count < REPORT_MAX) begin
               $display("unexpected frame byte %02h last %0b", rsp_frame_byte, rsp_last_byte);
            end
            mismatch_count++;
         end else begin
            want = pending_bytes.pop_front();
            if (want.octet !== rsp_frame_byte || want.last !== rsp_last_byte) begin
               if (mismatch_count < REPORT_MAX) begin
                  $display("frame pos %0d: expected byte %02h last %0b, got byte %02h last %0b",
                           want.pos, want.octet, want.last, rsp_frame_byte, rsp_last_byte);
               end
               mismatch_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // stimulus
   initial begin
      int per_phase;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_start_address  = 16'h0000;
      req_register_count = 16'h0000;
      csr_write_enable   = 1'b0;
      csr_index          = 8'h00;
      csr_write_data     = 32'h0000_0000;
      model_slave        = vmrf_pkg::SLAVE_ID_RESET;
      model_serial       = 32'h0000_0000;
      model_seq          = vmrf_pkg::SEQ_RESET;
      per_phase          = RANDOM_ITEMS / RANDOM_PHASES;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      for (int r = 0; r < $size(DIRECTED_PLAN); r++) begin
         if (DIRECTED_PLAN[r].kind == ROW_CSR) begin
            wait_idle();
            csr_write(DIRECTED_PLAN[r].a[7:0], DIRECTED_PLAN[r].data);
         end else begin
            send_request(DIRECTED_PLAN[r].a, DIRECTED_PLAN[r].b, DIRECTED_PLAN[r].spot,
                         DIRECTED_PLAN[r].pos, DIRECTED_PLAN[r].val);
         end
      end

      // random phases, each under a fresh register setting
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         wait_idle();
         csr_write(vmrf_pkg::CSR_SLAVE_ID, $urandom);
         case (ph)
            1: begin
               csr_write(vmrf_pkg::CSR_LOGGER_SERIAL, 32'h0000_0000);
            end
            4: begin
               csr_write(vmrf_pkg::CSR_LOGGER_SERIAL, 32'hFFFF_FFFF);
            end
            default: begin
               csr_write(vmrf_pkg::CSR_LOGGER_SERIAL, $urandom);
            end
         endcase
         if (ph == 3) begin
            csr_write(8'($urandom_range(CSR_UNUSED_IDX, CSR_TOP_IDX)), $urandom);
         end
         if (ph == 2) begin
            hold_go = 1'b1;
         end
         for (int n = 0; n < per_phase; n++) begin
            send_request(pick_field(), pick_field(), 1'b0, vmrf_pkg::POS_START,
                         vmrf_pkg::ZERO_BYTE);
         end
      end

      // drain and settle
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_bytes.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/vmrf_pkg.sv
hw/rtl/vmrf_req_reg.sv
hw/rtl/vmrf_frame_gen.sv
hw/rtl/vmrf_rsp_reg.sv
hw/rtl/v5_modbus_request_framer_top.sv
tb/v5_modbus_request_framer_top_tb.sv
